/* rtl/core/nlt_pkg.sv */
// Package for the neighbor liveness table: operation and status codes,
// controller states, register map and reset values. No dependencies.
`default_nettype none
package nlt_pkg;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_HEARTBEAT = 2'd1,
    OP_TICK      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_APPENDED  = 2'd0,
    ST_REFRESHED = 2'd1,
    ST_FULL      = 2'd2,
    ST_TICK_DONE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_AGE,
    S_APPEND,
    S_FINISH
  } state_t;

  localparam logic REG_AGE_INCREMENT = 1'b0;
  localparam logic REG_EXPIRE_LIMIT  = 1'b1;

  localparam logic [7:0] AGE_INCREMENT_RESET = 8'd5;
  localparam logic [7:0] EXPIRE_LIMIT_RESET  = 8'd15;
  localparam logic [7:0] AGE_MAX             = 8'hFF;

  localparam int ADDR_BITS = 32;
  localparam int AGE_BITS  = 8;

endpackage
`default_nettype wire

/* rtl/core/nlt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none
module nlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/neighbor_liveness_table_top.sv */
// Neighbor liveness table top level: request handshake, table controller,
// APB register file. Depends on nlt_pkg and nlt_ram.
//
// Usage:
//   Requests enter on in_valid/in_ready with operation, node_key and
//   node_address; one result per request leaves on out_valid/out_ready
//   with status, entry_count and removed_count.
//   in_ready is high only while the controller is idle; one request is
//   worked on at a time. The table is one memory holding key, address and
//   age of each entry, read one entry per cycle through its registered port.
//   A start request appends its entry; a heartbeat sweeps the table for its
//   key, clears that entry's age on a match and else appends; a tick sweeps
//   all live entries, adds age_increment (saturating) and drops those that
//   reach or pass expire_limit; operation three only returns a result. No
//   request is taken before the last one has reached its result, and the
//   next one can be taken as soon as out_valid rises.
//   A stalled result waits in the output register; the next request is
//   still taken, and its result is held back until the register is free.
//   Reset (rst, synchronous) clears the live count; entry contents are left.
//   age_increment returns to 5, expire_limit to 15 (byte addresses 0 and 4).
`default_nettype none
module neighbor_liveness_table_top #(
  parameter int TABLE_ENTRIES = 128,
  parameter int KEY_BITS      = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [63:0] node_key,
  input  wire logic [31:0] node_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       entry_count,
  output logic [7:0]       removed_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import nlt_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int W  = KEY_BITS + ADDR_BITS + AGE_BITS;

  state_t                state, state_next;
  op_t                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         rd_ptr, rd_ptr_next;
  logic [CW-1:0]         wr_ptr, wr_ptr_next;
  logic [CW-1:0]         removed, removed_next;
  logic                  chk_valid, chk_valid_next;
  logic [IW-1:0]         chk_idx, chk_idx_next;
  status_t               res_status, res_status_next;
  logic [7:0]            age_increment;
  logic [7:0]            expire_limit;
  logic                  load_out;
  logic                  accept;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [W-1:0]          wdata;
  logic [IW-1:0]         raddr;
  logic [W-1:0]          rdata;

  logic [KEY_BITS-1:0]   rd_key;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [AGE_BITS-1:0]   rd_age;
  logic [AGE_BITS:0]     age_sum;
  logic [AGE_BITS-1:0]   age_new;
  logic                  issue;
  logic [CW+7:0]         count_ext;
  logic [CW+7:0]         removed_ext;

  nlt_ram #(
    .WIDTH(W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign rd_key  = rdata[W-1 -: KEY_BITS];
  assign rd_addr = rdata[AGE_BITS +: ADDR_BITS];
  assign rd_age  = rdata[AGE_BITS-1:0];
  assign age_sum = {1'b0, rd_age} + {1'b0, age_increment};
  assign age_new = age_sum[AGE_BITS] ? AGE_MAX : age_sum[AGE_BITS-1:0];
  assign issue   = (rd_ptr < count);

  assign count_ext   = {8'd0, count};
  assign removed_ext = {8'd0, removed};

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    removed_next    = removed;
    chk_valid_next  = chk_valid;
    chk_idx_next    = chk_idx;
    res_status_next = res_status;
    load_out        = 1'b0;
    we              = 1'b0;
    waddr           = count[IW-1:0];
    wdata           = {key_q, addr_q, {AGE_BITS{1'b0}}};
    raddr           = rd_ptr[IW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rd_ptr_next     = '0;
          wr_ptr_next     = '0;
          removed_next    = '0;
          chk_valid_next  = 1'b0;
          res_status_next = ST_TICK_DONE;
          unique case (op_t'(operation))
            OP_START:     state_next = S_APPEND;
            OP_HEARTBEAT: state_next = S_SCAN;
            OP_TICK:      state_next = S_AGE;
            default:      state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (chk_valid && (rd_key == key_q)) begin
          we              = 1'b1;
          waddr           = chk_idx;
          wdata           = {rd_key, rd_addr, {AGE_BITS{1'b0}}};
          res_status_next = ST_REFRESHED;
          chk_valid_next  = 1'b0;
          state_next      = S_FINISH;
        end else if (!chk_valid && !issue) begin
          state_next = S_APPEND;
        end else begin
          chk_valid_next = issue;
          chk_idx_next   = rd_ptr[IW-1:0];
          rd_ptr_next    = rd_ptr + CW'(issue);
        end
      end
      S_AGE: begin
        if (!chk_valid && !issue) begin
          count_next      = wr_ptr;
          res_status_next = ST_TICK_DONE;
          state_next      = S_FINISH;
        end else begin
          if (chk_valid) begin
            if (age_new >= expire_limit) begin
              removed_next = removed + CW'(1);
            end else begin
              we          = 1'b1;
              waddr       = wr_ptr[IW-1:0];
              wdata       = {rd_key, rd_addr, age_new};
              wr_ptr_next = wr_ptr + CW'(1);
            end
          end
          chk_valid_next = issue;
          chk_idx_next   = rd_ptr[IW-1:0];
          rd_ptr_next    = rd_ptr + CW'(issue);
        end
      end
      S_APPEND: begin
        if (count < CW'(TABLE_ENTRIES)) begin
          we              = 1'b1;
          count_next      = count + CW'(1);
          res_status_next = ST_APPENDED;
        end else begin
          res_status_next = ST_FULL;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      chk_valid <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr     <= rd_ptr_next;
    wr_ptr     <= wr_ptr_next;
    removed    <= removed_next;
    chk_idx    <= chk_idx_next;
    res_status <= res_status_next;
    if (accept) begin
      op_q   <= op_t'(operation);
      key_q  <= node_key[KEY_BITS-1:0];
      addr_q <= node_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= res_status;
      entry_count   <= count_ext[7:0];
      removed_count <= (op_q == OP_TICK) ? removed_ext[7:0] : 8'd0;
    end
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_increment <= AGE_INCREMENT_RESET;
      expire_limit  <= EXPIRE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_EXPIRE_LIMIT) begin
        expire_limit <= pwdata[7:0];
      end else begin
        age_increment <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_EXPIRE_LIMIT) begin
      prdata = {24'd0, expire_limit};
    end else begin
      prdata = {24'd0, age_increment};
    end
  end

endmodule
`default_nettype wire
